// ===== design/pcmf_pkg.sv =====
// ---------------------------------------------------------------------------
// pcmf_pkg
// Shared codes, constants and helper functions for the PCM to float
// converter.
// ---------------------------------------------------------------------------
package pcmf_pkg;

	localparam int unsigned DefMaxChannels = 8;

	// sample formats
	localparam logic [2:0] FMT_U8  = 3'd0;
	localparam logic [2:0] FMT_S16 = 3'd1;
	localparam logic [2:0] FMT_S32 = 3'd2;
	localparam logic [2:0] FMT_F32 = 3'd3;
	localparam logic [2:0] FMT_F64 = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_FORMAT  = 2'd0;
	localparam logic [1:0] REG_IN_CHAN = 2'd1;
	localparam logic [1:0] REG_OUT_CHAN = 2'd2;

	// rounded single scale factors: significand and unbiased exponent
	localparam logic [23:0] K_U8_MANT  = 24'h810204;
	localparam logic [23:0] K_S16_MANT = 24'h800100;
	localparam logic [23:0] K_S32_MANT = 24'h800000;
	localparam logic signed [7:0] K_U8_EXP  = -8'sd7;
	localparam logic signed [7:0] K_S16_EXP = -8'sd15;
	localparam logic signed [7:0] K_S32_EXP = -8'sd31;

	// 1.0 in units of 2^-31
	localparam logic [33:0] ONE_FIX = 34'h080000000;

	localparam logic [30:0] INF_FIELD = 31'h7F800000;
	localparam logic [30:0] QNAN_FIELD = 31'h7FC00000;
	localparam logic [62:0] DBL_OVF_MAG = 63'h47EFFFFFF8000000;
	localparam logic [62:0] DBL_INF_MAG = 63'h7FF0000000000000;

	// leading zero count of a non-zero word
	function automatic logic [4:0] lzc32(input logic [31:0] w);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (w[i])
				n = 5'(31 - i);
		end
		return n;
	endfunction

	// round a normalised word to 24 bits, nearest even; bit 24 is the carry
	function automatic logic [24:0] rne24(input logic [31:0] w);
		logic up;
		up = w[7] & ((|w[6:0]) | w[8]);
		return {1'b0, w[31:8]} + {24'd0, up};
	endfunction

endpackage

// ===== design/pcm_sample_to_float.sv =====
// Each sample is registered in stages s1 to s8 between input transfer and result valid.
// Throughput: one sample per cycle; every stage holds on its own when the
// next one is full, so bubbles close up under back-pressure.
// Samples outside the active channel count or with an unknown format are
// dropped at the first stage. Reset (arst_n low, asynchronous) empties the
// pipeline and loads format 1 (signed 16) and two channels in and out.
// ---------------------------------------------------------------------------
// pcm_sample_to_float
// Converts PCM sample words of five formats to IEEE single precision.
// ---------------------------------------------------------------------------
module pcm_sample_to_float
	import pcmf_pkg::*;
#(
	parameter int unsigned MAX_CHANNELS = DefMaxChannels
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] raw_sample,
	input  logic [2:0]  chan_pos,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] float_bits,
	output logic [2:0]  chan_out,
	output logic        last_out
);

	localparam logic [6:0] ChanLimit = (MAX_CHANNELS > 15) ? 7'd15 : 7'(MAX_CHANNELS);

	logic [2:0] fmt_q;
	logic [3:0] in_chan_q;
	logic [3:0] out_chan_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q      <= FMT_S16;
			in_chan_q  <= 4'd2;
			out_chan_q <= 4'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FORMAT:   fmt_q      <= cfg_data[2:0];
				REG_IN_CHAN:  in_chan_q  <= cfg_data;
				REG_OUT_CHAN: out_chan_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control: a stage loads when it is empty or the next one loads
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8;
	logic keep;

	assign adv8 = !vld_s8 || out_ready;
	assign adv7 = !vld_s7 || adv8;
	assign adv6 = !vld_s6 || adv7;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
		end else begin
			if (adv1) vld_s1 <= in_valid && keep;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
			if (adv7) vld_s7 <= vld_s6;
			if (adv8) vld_s8 <= vld_s7;
		end
	end

	// ---- stage 1: channel check, integer sign and magnitude
	logic [3:0]  active;
	logic [6:0]  limit;
	logic        neg;
	logic [31:0] mag;

	assign active = (out_chan_q < in_chan_q) ? out_chan_q : in_chan_q;
	assign limit  = ({3'd0, active} < ChanLimit) ? {3'd0, active} : ChanLimit;
	assign keep   = ({4'd0, chan_pos} < limit) && (fmt_q <= FMT_F64);

	always_comb begin
		neg = 1'b0;
		mag = {24'd0, raw_sample[7:0]};
		case (fmt_q)
			FMT_S16: begin
				neg = raw_sample[15];
				mag = {16'd0, neg ? 16'(~raw_sample[15:0] + 16'd1) : raw_sample[15:0]};
			end
			FMT_S32: begin
				neg = raw_sample[31];
				mag = neg ? (~raw_sample[31:0] + 32'd1) : raw_sample[31:0];
			end
			default: ;
		endcase
	end

	logic [2:0]  fmt_s1, fmt_s2, fmt_s3, fmt_s4, fmt_s5, fmt_s6, fmt_s7;
	logic [2:0]  chan_s1, chan_s2, chan_s3, chan_s4, chan_s5, chan_s6, chan_s7;
	logic        last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	logic        sign_s1, sign_s2, sign_s3, sign_s4;
	logic [31:0] mag_s1;
	logic [63:0] word_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			fmt_s1  <= fmt_q;
			chan_s1 <= chan_pos;
			last_s1 <= last_in;
			sign_s1 <= neg;
			mag_s1  <= mag;
			word_s1 <= raw_sample;
		end
	end

	// ---- stage 2: integer normalise, double alignment
	logic [4:0]   lz1;
	logic [10:0]  dexp;
	logic [11:0]  rfull;
	logic [6:0]   rsh;
	logic [116:0] dshift;
	logic [30:0]  dbase;
	logic         dguard, dsticky;

	assign lz1   = lzc32(mag_s1);
	assign dexp  = word_s1[62:52];
	assign rfull = 12'd926 - {1'b0, dexp};
	assign rsh   = (dexp < 11'd871) ? 7'd55 : rfull[6:0];
	assign dshift = {1'b1, word_s1[51:0], 64'd0} >> rsh;

	always_comb begin
		if (dexp > 11'd896) begin
			dbase   = {8'(dexp - 11'd896), word_s1[51:29]};
			dguard  = word_s1[28];
			dsticky = |word_s1[27:0];
		end else begin
			dbase   = dshift[94:64];
			dguard  = dshift[63];
			dsticky = |dshift[62:0];
		end
	end

	logic [31:0] norm_s2;
	logic [4:0]  iexp_s2;
	logic        izero_s2;
	logic [30:0] dbase_s2;
	logic        dup_s2;
	logic        dnan_s2, dovf_s2, dsign_s2;
	logic [31:0] word_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			fmt_s2   <= fmt_s1;
			chan_s2  <= chan_s1;
			last_s2  <= last_s1;
			sign_s2  <= sign_s1;
			norm_s2  <= mag_s1 << lz1;
			iexp_s2  <= 5'd31 - lz1;
			izero_s2 <= (mag_s1 == 32'd0);
			dbase_s2 <= dbase;
			dup_s2   <= dguard & (dsticky | dbase[0]);
			dnan_s2  <= word_s1[62:0] > DBL_INF_MAG;
			dovf_s2  <= word_s1[62:0] >= DBL_OVF_MAG;
			dsign_s2 <= word_s1[63];
			word_s2  <= (fmt_s1 == FMT_F32) ? word_s1[31:0]
				: {word_s1[63], 8'd0, word_s1[51:29]};
		end
	end

	// ---- stage 3: integer rounding, double result
	logic [24:0] ir;
	logic [31:0] dres;

	assign ir = rne24(norm_s2);

	always_comb begin
		if (fmt_s2 == FMT_F32)
			dres = word_s2;
		else if (dnan_s2)
			dres = {dsign_s2, QNAN_FIELD | {8'd0, word_s2[22:0]}};
		else if (dovf_s2)
			dres = {dsign_s2, INF_FIELD};
		else
			dres = {dsign_s2, dbase_s2 + {30'd0, dup_s2}};
	end

	logic [23:0] am_s3;
	logic [5:0]  ae_s3;
	logic        azero_s3;
	logic [31:0] direct_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			fmt_s3    <= fmt_s2;
			chan_s3   <= chan_s2;
			last_s3   <= last_s2;
			sign_s3   <= sign_s2;
			am_s3     <= ir[24] ? ir[24:1] : ir[23:0];
			ae_s3     <= {1'b0, iexp_s2} + {5'd0, ir[24]};
			azero_s3  <= izero_s2;
			direct_s3 <= dres;
		end
	end

	// ---- stage 4: scale multiply
	logic [23:0]       kmant;
	logic signed [7:0] kexp;

	always_comb begin
		case (fmt_s3)
			FMT_U8: begin
				kmant = K_U8_MANT;
				kexp  = K_U8_EXP;
			end
			FMT_S16: begin
				kmant = K_S16_MANT;
				kexp  = K_S16_EXP;
			end
			default: begin
				kmant = K_S32_MANT;
				kexp  = K_S32_EXP;
			end
		endcase
	end

	logic [47:0]       prod_s4;
	logic signed [7:0] pe_s4;
	logic              pzero_s4;
	logic [31:0]       direct_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			fmt_s4    <= fmt_s3;
			chan_s4   <= chan_s3;
			last_s4   <= last_s3;
			sign_s4   <= sign_s3;
			prod_s4   <= am_s3 * kmant;
			pe_s4     <= signed'({2'b00, ae_s3}) + kexp;
			pzero_s4  <= azero_s3;
			direct_s4 <= direct_s3;
		end
	end

	// ---- stage 5: product normalise and round
	logic              phi;
	logic [31:0]       pwin;
	logic [24:0]       pr;
	logic [23:0]       bm;
	logic signed [7:0] be;
	logic [31:0]       bfloat;

	assign phi  = prod_s4[47];
	assign pwin = phi ? prod_s4[47:16] : prod_s4[46:15];
	assign pr   = rne24({pwin[31:1], (|prod_s4[14:0]) | pwin[0]});
	assign bm   = pr[24] ? pr[24:1] : pr[23:0];
	assign be   = pe_s4 + signed'({6'd0, phi}) + signed'({6'd0, pr[24]});
	assign bfloat = pzero_s4 ? 32'd0 : {sign_s4, 8'(be + 8'sd127), bm[22:0]};

	logic [23:0]       bm_s5;
	logic signed [7:0] be_s5;
	logic              bzero_s5;
	logic [31:0]       res_s5, res_s6, res_s7;

	always_ff @(posedge clk) begin
		if (adv5) begin
			fmt_s5   <= fmt_s4;
			chan_s5  <= chan_s4;
			last_s5  <= last_s4;
			bm_s5    <= bm;
			be_s5    <= be;
			bzero_s5 <= pzero_s4;
			res_s5   <= (fmt_s4 <= FMT_S32) ? bfloat : direct_s4;
		end
	end

	// ---- stage 6: unsigned 8 path, subtract one in fixed point
	logic [3:0]  bsh;
	logic [32:0] bfix;

	assign bsh  = 4'(be_s5 + 8'sd8);
	assign bfix = bzero_s5 ? 33'd0 : ({9'd0, bm_s5} << bsh);

	logic [33:0] diff_s6;

	always_ff @(posedge clk) begin
		if (adv6) begin
			fmt_s6  <= fmt_s5;
			chan_s6 <= chan_s5;
			last_s6 <= last_s5;
			res_s6  <= res_s5;
			diff_s6 <= {1'b0, bfix} - ONE_FIX;
		end
	end

	// ---- stage 7: difference magnitude and normalise
	logic [33:0] dabs;
	logic [4:0]  lz2;

	assign dabs = diff_s6[33] ? (~diff_s6 + 34'd1) : diff_s6;
	assign lz2  = lzc32(dabs[31:0]);

	logic [31:0] unorm_s7;
	logic [4:0]  ulz_s7;
	logic        usign_s7, uzero_s7;

	always_ff @(posedge clk) begin
		if (adv7) begin
			fmt_s7   <= fmt_s6;
			chan_s7  <= chan_s6;
			last_s7  <= last_s6;
			res_s7   <= res_s6;
			unorm_s7 <= dabs[31:0] << lz2;
			ulz_s7   <= lz2;
			usign_s7 <= diff_s6[33];
			uzero_s7 <= (dabs[31:0] == 32'd0);
		end
	end

	// ---- stage 8: round the difference, output register
	logic [24:0] ur;
	logic [7:0]  uexp;
	logic [22:0] ufrac;
	logic [31:0] ures;

	assign ur    = rne24(unorm_s7);
	assign uexp  = 8'd127 - {3'd0, ulz_s7} + {7'd0, ur[24]};
	assign ufrac = ur[24] ? ur[23:1] : ur[22:0];
	assign ures  = uzero_s7 ? 32'd0 : {usign_s7, uexp, ufrac};

	logic [31:0] float_s8;
	logic [2:0]  chan_s8;
	logic        last_s8;

	always_ff @(posedge clk) begin
		if (adv8) begin
			float_s8 <= (fmt_s7 == FMT_U8) ? ures : res_s7;
			chan_s8  <= chan_s7;
			last_s8  <= last_s7;
		end
	end

	assign out_valid  = vld_s8;
	assign float_bits = float_s8;
	assign chan_out   = chan_s8;
	assign last_out   = last_s8;

endmodule

// ===== design/pcmf_checker.sv =====
// ---------------------------------------------------------------------------
// pcmf_checker
// Port-level checks for the PCM to float converter, bound to the top level.
// ---------------------------------------------------------------------------
module pcmf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_ready,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] float_bits,
	input logic [2:0]  chan_out,
	input logic        last_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(float_bits)
			&& $stable(chan_out) && $stable(last_out))
		else $error("result changed under stall");

	// an empty output register means the whole pipeline can advance
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown straight after reset");

endmodule

bind pcm_sample_to_float pcmf_checker u_pcmf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_ready  (cfg_ready),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.float_bits (float_bits),
	.chan_out   (chan_out),
	.last_out   (last_out)
);

// ===== tb/pcm_sample_to_float_tb.sv =====
// ---------------------------------------------------------------------------
// pcm_sample_to_float_tb
// Drives sample words through the PCM to float converter under several
// format and channel settings, predicts every single-precision result with
// an integer-exact rounding model and checks results in order, with random
// gaps on the input side and random stalls on the output side.
// ---------------------------------------------------------------------------
module pcm_sample_to_float_tb;
	import pcmf_pkg::*;

	localparam int unsigned IdleLimit = 5000;

	typedef struct packed {
		logic [63:0] raw;
		logic [2:0]  chan;
		logic        last;
	} sample_t;

	typedef struct packed {
		logic [31:0] bits;
		logic [2:0]  chan;
		logic        last;
	} conv_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [3:0]  cfg_data;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] raw_sample = '0;
	logic [2:0]  chan_pos = '0;
	logic        last_in = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] float_bits;
	logic [2:0]  chan_out;
	logic        last_out;

	sample_t     sample_q[$];
	conv_t       float_q[$];
	logic [2:0]  cur_fmt;
	logic [3:0]  cur_in_ch;
	logic [3:0]  cur_out_ch;
	int unsigned errors = 0;
	int unsigned idle_cycles = 0;

	pcm_sample_to_float i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_sample(raw_sample),
		.chan_pos(chan_pos),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.float_bits(float_bits),
		.chan_out(chan_out),
		.last_out(last_out)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// double pattern to single, nearest even, with overflow to infinity and quiet NaN
	function automatic logic [31:0] round_to_single(input logic [63:0] w);
		logic        sg;
		logic [62:0] mag;
		logic [52:0] sig;
		logic [53:0] q, rem, half;
		logic [31:0] m;
		int          ue, s;
		sg = w[63];
		mag = w[62:0];
		if (mag > DBL_INF_MAG)
			return {sg, QNAN_FIELD | {8'd0, mag[51:29]}};
		if (mag >= DBL_OVF_MAG)
			return {sg, INF_FIELD};
		if (mag[62:52] == 11'd0)
			return {sg, 31'd0};
		ue = int'(mag[62:52]) - 1023;
		sig = {1'b1, mag[51:0]};
		s = (ue >= -126) ? 29 : 29 + (-126 - ue);
		if (s > 54)
			return {sg, 31'd0};
		q = 54'(sig >> s);
		rem = 54'(sig) & ((54'd1 << s) - 54'd1);
		half = 54'd1 << (s - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 54'd1;
		// the hidden bit carries into the exponent field on its own
		if (ue >= -126)
			m = 32'((ue + 126) << 23) + 32'(q);
		else
			m = 32'(q);
		return {sg, m[30:0]};
	endfunction

	// widen a normal or zero single to a double
	function automatic real single_to_real(input logic [31:0] b);
		if (b[30:23] == 8'd0)
			return 0.0;
		return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
	endfunction

	function automatic logic channel_active(input logic [2:0] chan);
		logic [3:0] act;
		act = (cur_out_ch < cur_in_ch) ? cur_out_ch : cur_in_ch;
		if (act > 4'd8)
			act = 4'd8;
		return {1'b0, chan} < act;
	endfunction

	function automatic logic [31:0] convert_sample(input logic [63:0] raw);
		real         r;
		logic [31:0] b;
		case (cur_fmt)
			FMT_U8: begin
				r = real'(raw[7:0]) * real'(K_U8_MANT) / 1073741824.0;
				b = round_to_single($realtobits(r));
				b = round_to_single($realtobits(single_to_real(b) - 1.0));
			end
			FMT_S16: begin
				r = real'(int'($signed(raw[15:0]))) * real'(K_S16_MANT) / 274877906944.0;
				b = round_to_single($realtobits(r));
			end
			FMT_S32: begin
				b = round_to_single($realtobits(real'(int'($signed(raw[31:0])))));
				b = round_to_single($realtobits(single_to_real(b) / 2147483648.0));
			end
			FMT_F32: b = raw[31:0];
			default: b = round_to_single(raw);
		endcase
		return b;
	endfunction

	// sender: bursts of random length with random gaps
	int unsigned burst_left;
	int unsigned gap_left;
	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready && cur_fmt <= FMT_F64 && channel_active(chan_pos))
				float_q.push_back('{convert_sample(raw_sample), chan_pos, last_in});
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					s = sample_q.pop_front();
					raw_sample <= s.raw;
					chan_pos <= s.chan;
					last_in <= s.last;
					in_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern changes with the top two bits of a free-running counter
	logic [9:0] stall_cyc;
	always @(posedge clk or negedge arst_n) begin
		conv_t w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cyc <= '0;
		end else begin
			if (out_valid && out_ready) begin
				if (float_q.size() == 0) begin
					$display("%0t: unexpected result float_bits=%h chan_out=%0d last_out=%0d",
						$time, float_bits, chan_out, last_out);
					errors++;
				end else begin
					w = float_q.pop_front();
					if (float_bits !== w.bits) begin
						$display("%0t: float_bits expected %h actual %h", $time, w.bits, float_bits);
						errors++;
					end
					if (chan_out !== w.chan) begin
						$display("%0t: chan_out expected %0d actual %0d", $time, w.chan, chan_out);
						errors++;
					end
					if (last_out !== w.last) begin
						$display("%0t: last_out expected %0d actual %0d", $time, w.last, last_out);
						errors++;
					end
				end
			end
			stall_cyc <= stall_cyc + 10'd1;
			case (stall_cyc[9:8])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= 1'($urandom_range(0, 1));
				2'd2: out_ready <= (stall_cyc[1:0] != 2'd0);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// watchdog: cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FORMAT: cur_fmt = val[2:0];
			REG_IN_CHAN: cur_in_ch = val;
			REG_OUT_CHAN: cur_out_ch = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [3:0] fmt, input logic [3:0] ich, input logic [3:0] och);
		write_reg(REG_FORMAT, fmt);
		write_reg(REG_IN_CHAN, ich);
		write_reg(REG_OUT_CHAN, och);
	endtask

	task automatic add_sample(input logic [63:0] raw, input logic [2:0] chan, input logic last);
		sample_q.push_back('{raw, chan, last});
	endtask

	// wait out the pipeline, including samples that were dropped
	task automatic drain;
		while (sample_q.size() > 0 || in_valid || float_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [63:0] random_double;
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: ;
			1: w[62:52] = 11'($urandom_range(1023 - 160, 1023 + 130));
			2: w[62:52] = 11'($urandom_range(1023 - 126, 1023 + 127));
			3: w[62:52] = 11'($urandom_range(1023 - 152, 1023 - 124));
			4: w[62:0] = DBL_OVF_MAG + 63'($signed(4'($urandom_range(0, 15))) );
			default: w[62:52] = ($urandom_range(0, 1) == 0) ? 11'h7FF : 11'h000;
		endcase
		return w;
	endfunction

	initial begin
		int unsigned f;
		logic [3:0]  act;
		logic [63:0] raw;
		logic [2:0]  chan;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FORMAT;
		cfg_data = '0;
		cur_fmt = FMT_S16;
		cur_in_ch = 4'd2;
		cur_out_ch = 4'd2;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: signed 16, two channels
		add_sample(64'h7FFF, 3'd0, 1'b0);
		add_sample(64'h8000, 3'd1, 1'b0);
		add_sample(64'h0, 3'd0, 1'b0);
		add_sample(64'hFFFF_FFFF_FFFF_0001, 3'd1, 1'b1);
		add_sample(64'hFFFF, 3'd2, 1'b0);
		drain();
		set_config({1'b0, FMT_U8}, 4'd8, 4'd8);
		add_sample(64'h0, 3'd0, 1'b0);
		add_sample(64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b1);
		add_sample(64'd127, 3'd3, 1'b0);
		add_sample(64'd128, 3'd4, 1'b0);
		drain();
		set_config({1'b0, FMT_S32}, 4'd1, 4'd8);
		add_sample(64'h7FFF_FFFF, 3'd0, 1'b0);
		add_sample(64'h8000_0000, 3'd0, 1'b1);
		add_sample(64'h0100_0001, 3'd0, 1'b0);
		add_sample(64'h1234, 3'd1, 1'b0);
		drain();
		set_config({1'b0, FMT_F32}, 4'd15, 4'd15);
		add_sample(64'h7F80_0001, 3'd7, 1'b0);
		add_sample(64'h8000_0000, 3'd5, 1'b0);
		drain();
		set_config({1'b0, FMT_F64}, 4'd8, 4'd1);
		add_sample(64'h7FF0_0000_0000_0001, 3'd0, 1'b0);
		add_sample(64'hFFF8_0000_0000_0000, 3'd0, 1'b0);
		add_sample({1'b0, DBL_OVF_MAG}, 3'd0, 1'b0);
		add_sample({1'b1, DBL_OVF_MAG - 63'd1}, 3'd0, 1'b1);
		add_sample(64'h3690_0000_0000_0001, 3'd0, 1'b0);
		add_sample(64'h0000_0000_0000_0001, 3'd0, 1'b0);
		drain();
		set_config(4'd7, 4'd0, 4'd8);
		add_sample(64'h1, 3'd0, 1'b0);
		drain();
		write_reg(REG_FORMAT, {1'b0, FMT_S16});
		add_sample(64'h1, 3'd0, 1'b0);
		drain();

		for (int p = 0; p < 10; p++) begin
			f = $urandom_range(0, 11);
			set_config((f < 10) ? 4'(f % 5) : 4'(5 + f % 3),
				($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8)),
				($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8)));
			act = (cur_out_ch < cur_in_ch) ? cur_out_ch : cur_in_ch;
			if (act > 4'd8)
				act = 4'd8;
			for (int k = 0; k < 115; k++) begin
				raw = {$urandom, $urandom};
				if (cur_fmt == FMT_F64 && $urandom_range(0, 2) != 0)
					raw = random_double();
				if (act != 0 && $urandom_range(0, 6) != 0)
					chan = 3'($urandom_range(0, act - 1));
				else
					chan = 3'($urandom_range(0, 7));
				add_sample(raw, chan, $urandom_range(0, 15) == 0);
			end
			drain();
		end

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
